// ===== hdl/mwo_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwo_pkg
// Shared types, constants and helpers of the mecanum wheel odometry core.
// ----------------------------------------------------------------------------
package mwo_pkg;

  localparam int MUL_A_W = 64;
  localparam int MUL_B_W = 32;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int DIV_N_W = 96;
  localparam int DIV_D_W = 64;

  localparam logic [2:0] REG_WHEEL_RADIUS   = 3'd0;
  localparam logic [2:0] REG_HALF_TRACK_SUM = 3'd1;
  localparam logic [2:0] REG_LEVER_SUM      = 3'd2;
  localparam logic [2:0] REG_COUNTS_PER_REV = 3'd3;
  localparam logic [2:0] REG_GEAR_RATIO     = 3'd4;

  localparam logic [15:0] RST_WHEEL_RADIUS   = 16'd4588;
  localparam logic [15:0] RST_HALF_TRACK_SUM = 16'd24183;
  localparam logic [15:0] RST_LEVER_SUM      = 16'd24183;
  localparam logic [15:0] RST_COUNTS_PER_REV = 16'd42;
  localparam logic [15:0] RST_GEAR_RATIO     = 16'd13107;

  localparam logic [31:0] US_PER_S = 32'd1000000;

  typedef struct packed {
    logic        [47:0] stamp_us;
    logic signed [31:0] count_fl;
    logic signed [31:0] count_fr;
    logic signed [31:0] count_rl;
    logic signed [31:0] count_rr;
  } mwo_in_t;

  typedef struct packed {
    logic signed [31:0] body_vx;
    logic signed [31:0] body_vy;
    logic signed [31:0] body_wz;
    logic signed [31:0] speed_fl;
    logic signed [31:0] speed_fr;
    logic signed [31:0] speed_rr;
    logic signed [31:0] speed_rl;
    logic               time_error;
  } mwo_out_t;

  typedef enum logic [12:0] {
    ST_IDLE = 13'b0000000000001,
    ST_K1   = 13'b0000000000010,
    ST_K    = 13'b0000000000100,
    ST_DEN  = 13'b0000000001000,
    ST_NUM  = 13'b0000000010000,
    ST_WDIV = 13'b0000000100000,
    ST_VX   = 13'b0000001000000,
    ST_VY   = 13'b0000010000000,
    ST_WZM  = 13'b0000100000000,
    ST_WZD  = 13'b0001000000000,
    ST_TERM = 13'b0010000000000,
    ST_SPD  = 13'b0100000000000,
    ST_DONE = 13'b1000000000000
  } mwo_state_t;

  // Apply sign to a magnitude and clamp to the signed 32-bit range.
  function automatic logic [31:0] sat_mag(input logic [95:0] mag, input logic neg);
    logic [31:0] res;
    if (neg) begin
      if (mag > 96'h80000000) res = 32'h80000000;
      else res = 32'(-mag[31:0]);
    end else begin
      if (mag > 96'h7FFFFFFF) res = 32'h7FFFFFFF;
      else res = mag[31:0];
    end
    return res;
  endfunction

endpackage

// ===== hdl/mwo_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwo_mul
// Unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module mwo_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [mwo_pkg::MUL_A_W-1:0] op_a,
  input  logic [mwo_pkg::MUL_B_W-1:0] op_b,
  output logic                        done,
  output logic [mwo_pkg::MUL_P_W-1:0] prod
);
  import mwo_pkg::*;

  logic [MUL_A_W-1:0] a_r;
  logic [MUL_P_W-1:0] p_r;
  logic [5:0]         cnt_r;
  logic               done_r;
  logic [MUL_A_W:0]   sum;

  assign sum  = {1'b0, p_r[MUL_P_W-1:MUL_B_W]} + (p_r[0] ? {1'b0, a_r} : '0);
  assign done = done_r;
  assign prod = p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= 6'(MUL_B_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= op_a;
      p_r <= {{MUL_A_W{1'b0}}, op_b};
    end else if (cnt_r != '0) begin
      p_r <= {sum, p_r[MUL_B_W-1:1]};
    end
  end

endmodule

// ===== hdl/mwo_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwo_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mwo_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [mwo_pkg::DIV_N_W-1:0] num,
  input  logic [mwo_pkg::DIV_D_W-1:0] den,
  output logic                        done,
  output logic [mwo_pkg::DIV_N_W-1:0] quo
);
  import mwo_pkg::*;

  logic [DIV_D_W-1:0] d_r;
  logic [DIV_D_W-1:0] rem_r;
  logic [DIV_N_W-1:0] q_r;
  logic [6:0]         cnt_r;
  logic               done_r;
  logic [DIV_D_W:0]   shifted;
  logic               fits;

  assign shifted = {rem_r, q_r[DIV_N_W-1]};
  assign fits    = shifted >= {1'b0, d_r};
  assign done    = done_r;
  assign quo     = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= 7'(DIV_N_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      d_r   <= den;
      rem_r <= '0;
      q_r   <= num;
    end else if (cnt_r != '0) begin
      rem_r <= fits ? DIV_D_W'(shifted - {1'b0, d_r}) : shifted[DIV_D_W-1:0];
      q_r   <= {q_r[DIV_N_W-2:0], fits};
    end
  end

endmodule

// ===== hdl/mecanum_wheel_odometry_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mecanum_wheel_odometry_core
// Wheel rates from encoder samples, body velocity and rebuilt wheel speeds.
// ----------------------------------------------------------------------------
// One request is processed at a time and yields one result. A request that
// updates the wheel rates runs the wheel-rate steps before the body velocity;
// a first sample or one with zero or backward time goes straight to the body
// velocity. The work is done by the shared 32-step shift-add multiplier and
// the shared 96-step restoring divider under the sequencer. A finished result
// waits in the output register while the next request is accepted.
module mecanum_wheel_odometry_core #(
  parameter int FRAC_BITS  = 16,
  parameter int COUNT_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mwo_pkg::mwo_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output mwo_pkg::mwo_out_t out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import mwo_pkg::*;

  localparam int CW = (COUNT_BITS < 32) ? COUNT_BITS : 32;
  localparam logic [63:0] C628 = 64'((628 * (64'd1 << FRAC_BITS) + 50) / 100);

  // configuration
  logic [15:0] radius_r, htrack_r, lever_r, cpr_r, gear_r;
  logic [2:0]  reg_idx;
  logic        cfg_wr;

  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    unique case (reg_idx)
      REG_WHEEL_RADIUS:   prdata = {16'd0, radius_r};
      REG_HALF_TRACK_SUM: prdata = {16'd0, htrack_r};
      REG_LEVER_SUM:      prdata = {16'd0, lever_r};
      REG_COUNTS_PER_REV: prdata = {16'd0, cpr_r};
      REG_GEAR_RATIO:     prdata = {16'd0, gear_r};
      default:            prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RST_WHEEL_RADIUS;
      htrack_r <= RST_HALF_TRACK_SUM;
      lever_r  <= RST_LEVER_SUM;
      cpr_r    <= RST_COUNTS_PER_REV;
      gear_r   <= RST_GEAR_RATIO;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_WHEEL_RADIUS:   radius_r <= pwdata[15:0];
        REG_HALF_TRACK_SUM: htrack_r <= pwdata[15:0];
        REG_LEVER_SUM:      lever_r  <= pwdata[15:0];
        REG_COUNTS_PER_REV: cpr_r    <= pwdata[15:0];
        REG_GEAR_RATIO:     gear_r   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  logic [15:0] r_eff, sh_eff, cpr_eff;
  assign r_eff   = (radius_r == '0) ? 16'd1 : radius_r;
  assign sh_eff  = (htrack_r == '0) ? 16'd1 : htrack_r;
  assign cpr_eff = (cpr_r == '0) ? 16'd1 : cpr_r;

  // state
  mwo_state_t         state_r, state_nxt;
  logic               run_r, run_nxt;
  logic               primed_r;
  logic [47:0]        last_stamp_r;
  logic signed [31:0] last_cnt_r [3];
  logic signed [32:0] diff_r [3];
  logic [47:0]        dt_r;
  logic               upd_r, terr_r;
  logic [1:0]         widx_r, sidx_r;
  logic [63:0]        k_r, den_r;
  logic signed [31:0] rate_r [3];
  logic signed [31:0] vx_r, vy_r, wz_r, term_r;
  logic signed [31:0] spd_r [4];
  logic               out_valid_r;
  mwo_out_t           out_data_r;

  logic accept;
  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  logic signed [31:0] cnt_in [3];
  assign cnt_in[0] = 32'($signed(in_data.count_fl[CW-1:0]));
  assign cnt_in[1] = 32'($signed(in_data.count_fr[CW-1:0]));
  assign cnt_in[2] = 32'($signed(in_data.count_rr[CW-1:0]));

  // operand shaping
  logic signed [32:0] s_vx, s_vy, s_wz, d_sel;
  logic [32:0]        a_vx, a_vy, a_wz, a_d;
  logic [31:0]        a_wzr;
  logic signed [33:0] e_sel;
  logic [33:0]        a_e;

  assign s_vx  = 33'(rate_r[0]) + 33'(rate_r[1]);
  assign s_vy  = 33'(rate_r[1]) - 33'(rate_r[2]);
  assign s_wz  = 33'(rate_r[2]) - 33'(rate_r[0]);
  assign a_vx  = s_vx[32] ? 33'(-s_vx) : 33'(s_vx);
  assign a_vy  = s_vy[32] ? 33'(-s_vy) : 33'(s_vy);
  assign a_wz  = s_wz[32] ? 33'(-s_wz) : 33'(s_wz);
  assign a_wzr = wz_r[31] ? 32'(-wz_r) : 32'(wz_r);
  assign d_sel = diff_r[widx_r];
  assign a_d   = d_sel[32] ? 33'(-d_sel) : 33'(d_sel);

  always_comb begin
    unique case (sidx_r)
      2'd0:    e_sel = 34'(vx_r) - 34'(vy_r) - 34'(term_r);
      2'd1:    e_sel = 34'(vx_r) + 34'(vy_r) + 34'(term_r);
      2'd2:    e_sel = 34'(vx_r) - 34'(vy_r) + 34'(term_r);
      default: e_sel = 34'(vx_r) + 34'(vy_r) - 34'(term_r);
    endcase
  end
  assign a_e = e_sel[33] ? 34'(-e_sel) : 34'(e_sel);

  // shared units
  logic               mul_start, mul_done, div_start, div_done;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;
  logic [DIV_N_W-1:0] div_n, div_q;
  logic [DIV_D_W-1:0] div_d;

  mwo_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .done  (mul_done),
    .prod  (mul_p)
  );

  mwo_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_n),
    .den   (div_d),
    .done  (div_done),
    .quo   (div_q)
  );

  always_comb begin
    unique case (state_r)
      ST_K1:   begin mul_a = C628;                 mul_b = {16'd0, gear_r};  end
      ST_K:    begin mul_a = k_r;                  mul_b = US_PER_S;         end
      ST_DEN:  begin mul_a = {16'd0, dt_r};        mul_b = {16'd0, cpr_eff}; end
      ST_NUM:  begin mul_a = k_r;                  mul_b = a_d[31:0];        end
      ST_VX:   begin mul_a = 64'(a_vx);            mul_b = {16'd0, r_eff};   end
      ST_VY:   begin mul_a = 64'(a_vy);            mul_b = {16'd0, r_eff};   end
      ST_WZM:  begin mul_a = 64'(a_wz);            mul_b = {16'd0, r_eff};   end
      ST_TERM: begin mul_a = 64'(a_wzr);           mul_b = {16'd0, lever_r}; end
      default: begin mul_a = '0;                   mul_b = '0;               end
    endcase
  end

  always_comb begin
    unique case (state_r)
      ST_WDIV: begin div_n = mul_p;                div_d = den_r;                  end
      ST_WZD:  begin div_n = mul_p;                div_d = {47'd0, sh_eff, 1'b0};  end
      ST_SPD:  begin div_n = 96'({a_e, 16'd0});    div_d = {48'd0, r_eff};         end
      default: begin div_n = '0;                   div_d = '0;                     end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    run_nxt   = run_r;
    mul_start = 1'b0;
    div_start = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = (primed_r && (in_data.stamp_us > last_stamp_r)) ? ST_K1 : ST_VX;
      end
      ST_K1, ST_K, ST_DEN, ST_NUM, ST_VX, ST_VY, ST_WZM, ST_TERM: begin
        mul_start = !run_r;
        run_nxt   = 1'b1;
        if (run_r && mul_done) begin
          run_nxt = 1'b0;
          unique case (state_r)
            ST_K1:   state_nxt = ST_K;
            ST_K:    state_nxt = ST_DEN;
            ST_DEN:  state_nxt = ST_NUM;
            ST_NUM:  state_nxt = ST_WDIV;
            ST_VX:   state_nxt = ST_VY;
            ST_VY:   state_nxt = ST_WZM;
            ST_WZM:  state_nxt = ST_WZD;
            default: state_nxt = ST_SPD;
          endcase
        end
      end
      ST_WDIV, ST_WZD, ST_SPD: begin
        div_start = !run_r;
        run_nxt   = 1'b1;
        if (run_r && div_done) begin
          run_nxt = 1'b0;
          unique case (state_r)
            ST_WDIV: state_nxt = (widx_r == 2'd2) ? ST_VX : ST_NUM;
            ST_WZD:  state_nxt = ST_TERM;
            default: state_nxt = (sidx_r == 2'd3) ? ST_DONE : ST_SPD;
          endcase
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      run_r        <= 1'b0;
      primed_r     <= 1'b0;
      last_stamp_r <= '0;
      for (int i = 0; i < 3; i++) begin
        last_cnt_r[i] <= '0;
        rate_r[i]     <= '0;
      end
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      run_r   <= run_nxt;
      if (accept) begin
        primed_r     <= 1'b1;
        last_stamp_r <= in_data.stamp_us;
        for (int i = 0; i < 3; i++) last_cnt_r[i] <= cnt_in[i];
      end
      if (state_r == ST_WDIV && run_r && div_done)
        rate_r[widx_r] <= sat_mag({16'd0, div_q[95:16]}, d_sel[32]);
      if (state_r == ST_DONE && (!out_valid_r || !out_stall)) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < 3; i++) diff_r[i] <= 33'(cnt_in[i]) - 33'(last_cnt_r[i]);
      dt_r   <= in_data.stamp_us - last_stamp_r;
      upd_r  <= primed_r && (in_data.stamp_us > last_stamp_r);
      terr_r <= primed_r && !(in_data.stamp_us > last_stamp_r);
      widx_r <= 2'd0;
      sidx_r <= 2'd0;
    end
    if (run_r && mul_done) begin
      unique case (state_r)
        ST_K1, ST_K: k_r   <= mul_p[63:0];
        ST_DEN:      den_r <= mul_p[63:0];
        ST_VX:       vx_r  <= sat_mag({17'd0, mul_p[95:17]}, s_vx[32]);
        ST_VY:       vy_r  <= sat_mag({17'd0, mul_p[95:17]}, s_vy[32]);
        ST_TERM:     term_r <= sat_mag({16'd0, mul_p[95:16]}, wz_r[31]);
        default: ;
      endcase
    end
    if (run_r && div_done) begin
      unique case (state_r)
        ST_WDIV: widx_r <= widx_r + 2'd1;
        ST_WZD:  wz_r   <= sat_mag(div_q, s_wz[32]);
        ST_SPD: begin
          spd_r[sidx_r] <= sat_mag(div_q, e_sel[33]);
          sidx_r        <= sidx_r + 2'd1;
        end
        default: ;
      endcase
    end
    if (state_r == ST_DONE && (!out_valid_r || !out_stall)) begin
      out_data_r.body_vx    <= vx_r;
      out_data_r.body_vy    <= vy_r;
      out_data_r.body_wz    <= wz_r;
      out_data_r.speed_fl   <= spd_r[0];
      out_data_r.speed_fr   <= spd_r[1];
      out_data_r.speed_rr   <= spd_r[2];
      out_data_r.speed_rl   <= spd_r[3];
      out_data_r.time_error <= terr_r && !upd_r;
    end
  end

endmodule
